@@ rtl/core/cwpf_pkg.sv @@
`timescale 1ns / 1ps

package cwpf_pkg;

    localparam int DIV1_STEPS = 32;
    localparam int SQRT_STEPS = 33;
    localparam int DIV2_STEPS = 32;
    localparam int LANES      = 3;

    localparam logic [1:0] REG_STEP_BASE  = 2'd0;
    localparam logic [1:0] REG_STEP_SPEED = 2'd1;
    localparam logic [1:0] REG_CONF_CAP   = 2'd2;

    localparam logic [30:0] STEP_BASE_RESET  = 31'd100000;
    localparam logic [15:0] STEP_SPEED_RESET = 16'd3000;
    localparam logic [15:0] CONF_CAP_RESET   = 16'd65535;

    typedef struct packed {
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] prev_z;
        logic [15:0] conf;
        logic [31:0] time_ms;
        logic [48:0] limit;
        logic [2:0]  neg;
        logic        total_zero;
        logic [31:0] step_x;
        logic [31:0] step_y;
        logic [31:0] step_z;
        logic [32:0] plen;
        logic        lim_zero;
        logic        scale;
    } side_t;

endpackage

@@ rtl/core/confidence_weighted_position_filter.sv @@
`timescale 1ns / 1ps

// Confidence-weighted position filter.
// The s_ channel takes one sample transaction per cycle while s_tready is
// high: previous filtered position, confidence and timestamp, raw position
// and timestamp, and the new confidence. The m_ channel returns one
// transaction per sample with the new position, the new confidence and the
// raw timestamp, in order. The three registers are written through the cfg_
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. A write takes effect at the next clock edge.
// Throughput is one transaction per cycle while no stall holds the pipeline,
// set by a fully pipelined datapath: a 32-stage weighted-step divider, a
// 33-stage square root giving the planar length and a 32-stage step-scaling
// divider, each retiring one bit per stage. Reset clears all valid bits and
// loads the register defaults. When the receiver stalls, one extra result is
// caught in a skid register, and the pipeline then holds until the output
// drains.
module confidence_weighted_position_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // prev_x_um, prev_y_um, prev_z_um, prev_confidence, prev_time_ms,
    // raw_x_um, raw_y_um, raw_z_um, raw_time_ms, new_confidence
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x_um, out_y_um, out_z_um, out_confidence, out_time_ms
    output logic [143:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    localparam int NL = cwpf_pkg::LANES;
    localparam int N1 = cwpf_pkg::DIV1_STEPS;
    localparam int NS = cwpf_pkg::SQRT_STEPS;
    localparam int N2 = cwpf_pkg::DIV2_STEPS;

    logic [30:0] base_reg;
    logic [15:0] speed_reg;
    logic [15:0] cap_reg;

    logic en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= cwpf_pkg::STEP_BASE_RESET;
            speed_reg <= cwpf_pkg::STEP_SPEED_RESET;
            cap_reg   <= cwpf_pkg::CONF_CAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cwpf_pkg::REG_STEP_BASE: begin
                    base_reg <= cfg_wdata;
                end
                cwpf_pkg::REG_STEP_SPEED: begin
                    speed_reg <= cfg_wdata[15:0];
                end
                cwpf_pkg::REG_CONF_CAP: begin
                    cap_reg <= cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: input register.
    logic         st1_v_reg;
    logic [287:0] st1_data_reg;

    // Stage 2: differences, weight sum and speed product.
    logic               st2_v_reg;
    cwpf_pkg::side_t    st2_side_reg;
    cwpf_pkg::side_t    st2_side_next;
    logic [31:0]        st2_mag_reg [NL];
    logic [31:0]        st2_mag_next [NL];
    logic [16:0]        st2_total_reg;
    logic [16:0]        st2_total_next;
    logic [47:0]        st2_prod_reg;
    logic [47:0]        st2_prod_next;

    // Stage 3: limit and weighted dividends.
    logic               st3_v_reg;
    cwpf_pkg::side_t    st3_side_reg;
    cwpf_pkg::side_t    st3_side_next;
    logic [47:0]        st3_dvd_reg [NL];
    logic [16:0]        st3_total_reg;

    always_comb begin
        logic signed [32:0] d;
        logic [31:0] prev_c [NL];
        logic [31:0] raw_c [NL];
        logic [15:0] pconf;
        logic [15:0] nconf;
        logic [15:0] mem;
        logic [31:0] elapsed;
        prev_c[0] = st1_data_reg[31:0];
        prev_c[1] = st1_data_reg[63:32];
        prev_c[2] = st1_data_reg[95:64];
        raw_c[0]  = st1_data_reg[175:144];
        raw_c[1]  = st1_data_reg[207:176];
        raw_c[2]  = st1_data_reg[239:208];
        pconf     = st1_data_reg[111:96];
        nconf     = st1_data_reg[287:272];
        elapsed   = st1_data_reg[271:240] - st1_data_reg[143:112];
        mem       = (pconf > cap_reg) ? cap_reg : pconf;
        st2_side_next         = '0;
        st2_side_next.prev_x  = prev_c[0];
        st2_side_next.prev_y  = prev_c[1];
        st2_side_next.prev_z  = prev_c[2];
        st2_side_next.conf    = nconf;
        st2_side_next.time_ms = st1_data_reg[271:240];
        for (int l = 0; l < NL; l++) begin
            d = $signed({raw_c[l][31], raw_c[l]}) - $signed({prev_c[l][31], prev_c[l]});
            st2_side_next.neg[l] = d[32];
            st2_mag_next[l] = d[32] ? 32'(-d) : d[31:0];
        end
        st2_total_next = {1'b0, mem} + {1'b0, nconf};
        st2_side_next.total_zero = (st2_total_next == 17'd0);
        st2_prod_next = {32'd0, speed_reg} * {16'd0, elapsed};
    end

    always_comb begin
        st3_side_next       = st2_side_reg;
        st3_side_next.limit = {18'd0, base_reg} + {1'b0, st2_prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_data_reg  <= s_tdata;
            st2_side_reg  <= st2_side_next;
            st2_mag_reg   <= st2_mag_next;
            st2_total_reg <= st2_total_next;
            st2_prod_reg  <= st2_prod_next;
            st3_side_reg  <= st3_side_next;
            st3_total_reg <= st2_total_reg;
            for (int l = 0; l < NL; l++) begin
                st3_dvd_reg[l] <= {16'd0, st2_mag_reg[l]} * {32'd0, st2_side_reg.conf};
            end
        end
    end

    // Weighted-step divider, one quotient bit per stage.
    logic               d1_v_reg [N1];
    cwpf_pkg::side_t    d1_side_reg [N1];
    logic [16:0]        d1_total_reg [N1];
    logic [16:0]        d1_rem_reg [N1][NL];
    logic [31:0]        d1_low_reg [N1][NL];
    logic [31:0]        d1_q_reg [N1][NL];
    logic [16:0]        d1_rem_next [N1][NL];
    logic [31:0]        d1_low_next [N1][NL];
    logic [31:0]        d1_q_next [N1][NL];

    always_comb begin
        logic [16:0] rem;
        logic [31:0] low;
        logic [31:0] q;
        logic [16:0] tot;
        logic [17:0] t;
        for (int k = 0; k < N1; k++) begin
            for (int l = 0; l < NL; l++) begin
                if (k == 0) begin
                    rem = {1'b0, st3_dvd_reg[l][47:32]};
                    low = st3_dvd_reg[l][31:0];
                    q   = '0;
                    tot = st3_total_reg;
                end else begin
                    rem = d1_rem_reg[k-1][l];
                    low = d1_low_reg[k-1][l];
                    q   = d1_q_reg[k-1][l];
                    tot = d1_total_reg[k-1];
                end
                t = {rem, low[31]};
                if (t >= {1'b0, tot}) begin
                    d1_rem_next[k][l] = 17'(t - {1'b0, tot});
                    d1_q_next[k][l]   = {q[30:0], 1'b1};
                end else begin
                    d1_rem_next[k][l] = t[16:0];
                    d1_q_next[k][l]   = {q[30:0], 1'b0};
                end
                d1_low_next[k][l] = {low[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_rem_reg <= d1_rem_next;
            d1_low_reg <= d1_low_next;
            d1_q_reg   <= d1_q_next;
            for (int k = 0; k < N1; k++) begin
                d1_side_reg[k]  <= (k == 0) ? st3_side_reg : d1_side_reg[k-1];
                d1_total_reg[k] <= (k == 0) ? st3_total_reg : d1_total_reg[k-1];
            end
        end
    end

    // Stages 4 to 6: step magnitudes, squares and planar sum.
    logic               st4_v_reg;
    cwpf_pkg::side_t    st4_side_reg;
    cwpf_pkg::side_t    st4_side_next;
    logic               st5_v_reg;
    cwpf_pkg::side_t    st5_side_reg;
    logic [63:0]        st5_sqx_reg;
    logic [63:0]        st5_sqy_reg;
    logic               st6_v_reg;
    cwpf_pkg::side_t    st6_side_reg;
    logic [64:0]        st6_rad_reg;

    always_comb begin
        st4_side_next = d1_side_reg[N1-1];
        if (d1_side_reg[N1-1].total_zero) begin
            st4_side_next.step_x = '0;
            st4_side_next.step_y = '0;
            st4_side_next.step_z = '0;
        end else begin
            st4_side_next.step_x = d1_q_reg[N1-1][0];
            st4_side_next.step_y = d1_q_reg[N1-1][1];
            st4_side_next.step_z = d1_q_reg[N1-1][2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_side_reg <= st4_side_next;
            st5_side_reg <= st4_side_reg;
            st5_sqx_reg  <= {32'd0, st4_side_reg.step_x} * {32'd0, st4_side_reg.step_x};
            st5_sqy_reg  <= {32'd0, st4_side_reg.step_y} * {32'd0, st4_side_reg.step_y};
            st6_side_reg <= st5_side_reg;
            st6_rad_reg  <= {1'b0, st5_sqx_reg} + {1'b0, st5_sqy_reg};
        end
    end

    // Square root giving the planar length, one root bit per stage.
    logic               sq_v_reg [NS];
    cwpf_pkg::side_t    sq_side_reg [NS];
    logic [34:0]        sq_rem_reg [NS];
    logic [65:0]        sq_rad_reg [NS];
    logic [32:0]        sq_root_reg [NS];
    logic [34:0]        sq_rem_next [NS];
    logic [65:0]        sq_rad_next [NS];
    logic [32:0]        sq_root_next [NS];

    always_comb begin
        logic [34:0] rem;
        logic [65:0] rad;
        logic [32:0] root;
        logic [36:0] t;
        logic [36:0] trial;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                rem  = '0;
                rad  = {1'b0, st6_rad_reg};
                root = '0;
            end else begin
                rem  = sq_rem_reg[k-1];
                rad  = sq_rad_reg[k-1];
                root = sq_root_reg[k-1];
            end
            t     = {rem, rad[65:64]};
            trial = {2'b00, root, 2'b01};
            if (t >= trial) begin
                sq_rem_next[k]  = 35'(t - trial);
                sq_root_next[k] = {root[31:0], 1'b1};
            end else begin
                sq_rem_next[k]  = t[34:0];
                sq_root_next[k] = {root[31:0], 1'b0};
            end
            sq_rad_next[k] = {rad[63:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg  <= sq_rem_next;
            sq_rad_reg  <= sq_rad_next;
            sq_root_reg <= sq_root_next;
            for (int k = 0; k < NS; k++) begin
                sq_side_reg[k] <= (k == 0) ? st6_side_reg : sq_side_reg[k-1];
            end
        end
    end

    // Stages 7 and 8: limit test and scaled-step products.
    logic               st7_v_reg;
    cwpf_pkg::side_t    st7_side_reg;
    cwpf_pkg::side_t    st7_side_next;
    logic               st8_v_reg;
    cwpf_pkg::side_t    st8_side_reg;
    logic [64:0]        st8_prod_reg [2];

    always_comb begin
        st7_side_next          = sq_side_reg[NS-1];
        st7_side_next.plen     = sq_root_reg[NS-1];
        st7_side_next.lim_zero = (sq_side_reg[NS-1].limit == 49'd0);
        st7_side_next.scale    = ({16'd0, sq_root_reg[NS-1]} > sq_side_reg[NS-1].limit);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_side_reg    <= st7_side_next;
            st8_side_reg    <= st7_side_reg;
            st8_prod_reg[0] <= {33'd0, st7_side_reg.step_x} * {32'd0, st7_side_reg.limit[32:0]};
            st8_prod_reg[1] <= {33'd0, st7_side_reg.step_y} * {32'd0, st7_side_reg.limit[32:0]};
        end
    end

    // Step-scaling divider, one quotient bit per stage.
    logic               d2_v_reg [N2];
    cwpf_pkg::side_t    d2_side_reg [N2];
    logic [32:0]        d2_rem_reg [N2][2];
    logic [31:0]        d2_low_reg [N2][2];
    logic [31:0]        d2_q_reg [N2][2];
    logic [32:0]        d2_rem_next [N2][2];
    logic [31:0]        d2_low_next [N2][2];
    logic [31:0]        d2_q_next [N2][2];

    always_comb begin
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] q;
        logic [32:0] dv;
        logic [33:0] t;
        for (int k = 0; k < N2; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    rem = st8_prod_reg[l][64:32];
                    low = st8_prod_reg[l][31:0];
                    q   = '0;
                    dv  = st8_side_reg.plen;
                end else begin
                    rem = d2_rem_reg[k-1][l];
                    low = d2_low_reg[k-1][l];
                    q   = d2_q_reg[k-1][l];
                    dv  = d2_side_reg[k-1].plen;
                end
                t = {rem, low[31]};
                if (t >= {1'b0, dv}) begin
                    d2_rem_next[k][l] = 33'(t - {1'b0, dv});
                    d2_q_next[k][l]   = {q[30:0], 1'b1};
                end else begin
                    d2_rem_next[k][l] = t[32:0];
                    d2_q_next[k][l]   = {q[30:0], 1'b0};
                end
                d2_low_next[k][l] = {low[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_rem_reg <= d2_rem_next;
            d2_low_reg <= d2_low_next;
            d2_q_reg   <= d2_q_next;
            for (int k = 0; k < N2; k++) begin
                d2_side_reg[k] <= (k == 0) ? st8_side_reg : d2_side_reg[k-1];
            end
        end
    end

    // Stage 9: final step selection and position update.
    logic               st9_v_reg;
    logic [143:0]       st9_data_reg;
    logic [143:0]       st9_data_next;
    cwpf_pkg::side_t    st9_in;
    logic [31:0]        fin_x;

    always_comb begin
        logic [31:0] fx;
        logic [31:0] fy;
        st9_in = d2_side_reg[N2-1];
        if (st9_in.lim_zero) begin
            fx = '0;
            fy = '0;
        end else if (st9_in.scale) begin
            fx = d2_q_reg[N2-1][0];
            fy = d2_q_reg[N2-1][1];
        end else begin
            fx = st9_in.step_x;
            fy = st9_in.step_y;
        end
        fin_x = st9_in.prev_x + (st9_in.neg[0] ? (~fx + 32'd1) : fx);
        st9_data_next[31:0]    = fin_x;
        st9_data_next[63:32]   = st9_in.prev_y + (st9_in.neg[1] ? (~fy + 32'd1) : fy);
        st9_data_next[95:64]   = st9_in.prev_z +
                                 (st9_in.neg[2] ? (~st9_in.step_z + 32'd1) : st9_in.step_z);
        st9_data_next[111:96]  = st9_in.conf;
        st9_data_next[143:112] = st9_in.time_ms;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st9_data_reg <= st9_data_next;
        end
    end

    // Valid bits of the whole pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            st4_v_reg <= 1'b0;
            st5_v_reg <= 1'b0;
            st6_v_reg <= 1'b0;
            st7_v_reg <= 1'b0;
            st8_v_reg <= 1'b0;
            st9_v_reg <= 1'b0;
            for (int k = 0; k < N1; k++) begin
                d1_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k < NS; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k < N2; k++) begin
                d2_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            st1_v_reg <= s_tvalid;
            st2_v_reg <= st1_v_reg;
            st3_v_reg <= st2_v_reg;
            for (int k = 0; k < N1; k++) begin
                d1_v_reg[k] <= (k == 0) ? st3_v_reg : d1_v_reg[k-1];
            end
            st4_v_reg <= d1_v_reg[N1-1];
            st5_v_reg <= st4_v_reg;
            st6_v_reg <= st5_v_reg;
            for (int k = 0; k < NS; k++) begin
                sq_v_reg[k] <= (k == 0) ? st6_v_reg : sq_v_reg[k-1];
            end
            st7_v_reg <= sq_v_reg[NS-1];
            st8_v_reg <= st7_v_reg;
            for (int k = 0; k < N2; k++) begin
                d2_v_reg[k] <= (k == 0) ? st8_v_reg : d2_v_reg[k-1];
            end
            st9_v_reg <= d2_v_reg[N2-1];
        end
    end

    // Output register with one skid entry.
    logic         out_v_reg;
    logic [143:0] out_data_reg;
    logic         skid_v_reg;
    logic [143:0] skid_data_reg;
    logic         out_free;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign out_free = m_tready || !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg  <= skid_v_reg || st9_v_reg;
            skid_v_reg <= 1'b0;
        end else if (st9_v_reg && en) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_v_reg ? skid_data_reg : st9_data_reg;
        end else if (st9_v_reg && en) begin
            skid_data_reg <= st9_data_reg;
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without a pending output");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        st9_v_reg && en && out_v_reg && !m_tready |=> skid_v_reg)
        else $error("result dropped while output stalled");

    a_scale_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        st7_v_reg && st7_side_reg.scale |->
            (st7_side_reg.plen != 33'd0) && (st7_side_reg.limit[48:33] == 16'd0))
        else $error("step scaling with out-of-range limit or length");

    a_zero_limit_holds_x: assert property (@(posedge aclk) disable iff (!aresetn)
        d2_v_reg[N2-1] && st9_in.lim_zero |-> fin_x == st9_in.prev_x)
        else $error("planar step not cleared for zero limit");

endmodule

@@ dv/cwpf_checker.sv @@
`timescale 1ns / 1ps

module cwpf_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,
    output int           fail_count,
    output int           pending,
    output int           checked
);

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] conf;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } position_t;

    logic [30:0] base_um;
    logic [15:0] speed_um_per_ms;
    logic [15:0] conf_cap;
    position_t   expected_positions[$];

    function automatic longint weighted_step(longint diff, longint mem, longint ncf);
        longint total;
        total = mem + ncf;
        if (total == 0) begin
            return 0;
        end
        return (diff * ncf) / total;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tw;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tw = {64'd0, t};
            if (tw * tw <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic longint clamp_step(longint s, logic [63:0] lim, logic [63:0] plen);
        logic [127:0] m;
        logic [127:0] q;
        m = (s < 0) ? -s : s;
        q = (m * {64'd0, lim}) / {64'd0, plen};
        return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic position_t filter_position(logic [287:0] d);
        position_t   p;
        longint      px, py, pz, rx, ry, rz, stx, sty, stz, mem, ncf;
        logic [31:0] elapsed;
        logic [63:0] lim;
        logic [63:0] plen;
        logic [127:0] ax, ay;
        px = longint'(signed'(d[31:0]));
        py = longint'(signed'(d[63:32]));
        pz = longint'(signed'(d[95:64]));
        rx = longint'(signed'(d[175:144]));
        ry = longint'(signed'(d[207:176]));
        rz = longint'(signed'(d[239:208]));
        mem = (d[111:96] > conf_cap) ? conf_cap : d[111:96];
        ncf = d[287:272];
        elapsed = d[271:240] - d[143:112];
        lim = 64'(base_um) + 64'(speed_um_per_ms) * 64'(elapsed);
        stx = weighted_step(rx - px, mem, ncf);
        sty = weighted_step(ry - py, mem, ncf);
        stz = weighted_step(rz - pz, mem, ncf);
        if (lim == 0) begin
            stx = 0;
            sty = 0;
        end else begin
            ax = (stx < 0) ? -stx : stx;
            ay = (sty < 0) ? -sty : sty;
            plen = floor_sqrt(ax * ax + ay * ay);
            if (plen > lim) begin
                stx = clamp_step(stx, lim, plen);
                sty = clamp_step(sty, lim, plen);
            end
        end
        p.x = 32'(px + stx);
        p.y = 32'(py + sty);
        p.z = 32'(pz + stz);
        p.conf = d[287:272];
        p.time_ms = d[271:240];
        return p;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("Mismatch on %s at %0t: expected %h, got %h", name, $time, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        position_t e;
        position_t a;
        if (!aresetn) begin
            base_um <= cwpf_pkg::STEP_BASE_RESET;
            speed_um_per_ms <= cwpf_pkg::STEP_SPEED_RESET;
            conf_cap <= cwpf_pkg::CONF_CAP_RESET;
            fail_count = 0;
            checked = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_positions.push_back(filter_position(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                a = m_tdata;
                if (expected_positions.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result transaction at %0t: %h", $time, m_tdata);
                    end
                end else begin
                    e = expected_positions.pop_front();
                    checked++;
                    compare_field("out_x_um", e.x, a.x);
                    compare_field("out_y_um", e.y, a.y);
                    compare_field("out_z_um", e.z, a.z);
                    compare_field("out_confidence", 32'(e.conf), 32'(a.conf));
                    compare_field("out_time_ms", e.time_ms, a.time_ms);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    cwpf_pkg::REG_STEP_BASE: begin
                        base_um <= cfg_wdata;
                    end
                    cwpf_pkg::REG_STEP_SPEED: begin
                        speed_um_per_ms <= cfg_wdata[15:0];
                    end
                    cwpf_pkg::REG_CONF_CAP: begin
                        conf_cap <= cfg_wdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = expected_positions.size();
    end

endmodule

@@ dv/confidence_weighted_position_filter_tb.sv @@
`timescale 1ns / 1ps

module confidence_weighted_position_filter_tb;

    localparam int LATENCY_WAIT = 130;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_STALL   = 400;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int settings_used;
    bit calm;
    bit stall_request;
    bit stall_served;
    bit gaps_on;
    int idle_cycles;

    confidence_weighted_position_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    cwpf_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_tready = 0;
        stall_served = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_served) begin
                m_tready = 0;
                repeat (LONG_STALL) @(negedge aclk);
                stall_served = 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_tready = 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [15:0] pc, logic [31:0] pt, logic [31:0] rx,
                               logic [31:0] ry, logic [31:0] rz, logic [31:0] rt,
                               logic [15:0] nc);
        s_tdata = {nc, rt, rz, ry, rx, pt, pc, pz, py, px};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] value);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic set_registers(logic [30:0] b, logic [15:0] sp, logic [15:0] cap);
        drain();
        write_reg(cwpf_pkg::REG_STEP_BASE, b);
        write_reg(cwpf_pkg::REG_STEP_SPEED, 31'(sp));
        write_reg(cwpf_pkg::REG_CONF_CAP, 31'(cap));
        settings_used++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic logic [15:0] pick_conf();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_sample();
        logic [31:0] px, py, pz, pt, dt;
        px = pick_coord();
        py = pick_coord();
        pz = pick_coord();
        pt = $urandom();
        dt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200);
        if ($urandom_range(0, 1)) begin
            send_sample(px, py, pz, pick_conf(), pt,
                        px + 32'($signed($urandom_range(0, 2000000)) - 1000000),
                        py + 32'($signed($urandom_range(0, 2000000)) - 1000000),
                        pz + 32'($signed($urandom_range(0, 2000000)) - 1000000),
                        pt + dt, pick_conf());
        end else begin
            send_sample(px, py, pz, pick_conf(), pt, pick_coord(), pick_coord(),
                        pick_coord(), pt + dt, pick_conf());
        end
    endtask

    task automatic random_run(int count);
        repeat (count) random_sample();
    endtask

    initial begin
        s_tvalid = 0;
        s_tdata = '0;
        cfg_wr_en = 0;
        cfg_index = cwpf_pkg::REG_STEP_BASE;
        cfg_wdata = '0;
        calm = 0;
        stall_request = 0;
        gaps_on = 1;
        settings_used = 1;
        aresetn = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        send_sample('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0, 32'd5,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3, 16'hFFFF);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 16'hFFFF);
        send_sample(32'd100, 32'd200, 32'd300, 16'd0, 32'd10,
                    32'd900, 32'd800, 32'd700, 32'd20, 16'd0);
        send_sample(32'd0, 32'd0, 32'd0, 16'd1, 32'd0,
                    32'd3000000, 32'd4000000, 32'hFFFF_0000, 32'd0, 16'd1);
        send_sample(32'd0, 32'd0, 32'd0, 16'd5, 32'd100,
                    32'd60000, 32'd80000, 32'd7, 32'd100, 16'd5);
        send_sample(32'hFFFF_FFFF, 32'd0, 32'd0, 16'd3, 32'hFFFF_FFF0,
                    32'hFF00_0000, 32'h0100_0000, 32'd9, 32'd16, 16'd7);
        send_sample(32'd0, 32'd0, 32'd0, 16'hFFFF, 32'd0,
                    32'd1000, 32'hFFFF_FC18, 32'd1000, 32'd1, 16'd1);
        send_sample(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 16'hAAAA, 32'hAAAA_AAAA,
                    32'hEDCB_A987, 32'h6543_2110, 32'hF0F0_F0F0, 32'h5555_5555, 16'h5555);
        send_sample(32'd0, 32'd0, 32'd0, 16'd0, 32'd0,
                    32'd70000, 32'd70000, 32'd0, 32'd0, 16'd9);

        set_registers(31'd0, 16'd0, 16'd0);
        send_sample(32'd0, 32'd0, 32'd0, 16'd100, 32'd7,
                    32'd5000, 32'hFFFF_EC78, 32'd5000, 32'd7, 16'd100);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'hFFFF, 32'd1,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd9, 16'hFFFF);
        send_sample(32'd1, 32'd2, 32'd3, 16'd0, 32'd0, 32'd4, 32'd5, 32'd6, 32'd0, 16'd0);
        random_run(200);

        set_registers(31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        random_run(200);

        set_registers(31'd0, 16'd1, 16'd1000);
        stall_request = 1;
        gaps_on = 0;
        random_run(250);
        gaps_on = 1;
        drain();
        random_run(100);

        set_registers(31'd5000, 16'd20, 16'd3);
        random_run(120);
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        random_run(120);

        set_registers(31'($urandom()), 16'($urandom()), 16'($urandom()));
        random_run(200);

        set_registers(cwpf_pkg::STEP_BASE_RESET, cwpf_pkg::STEP_SPEED_RESET,
                      cwpf_pkg::CONF_CAP_RESET);
        calm = 1;
        random_run(150);

        drain();
        $display("Checked %0d filtered positions across %0d register settings.",
                 checked, settings_used);
        $display("Covered clamped and unclamped steps, zero weights, time wrap and stalls.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
